// ===== sv/mh2_pkg.sv =====
// Shared types and constants of the MurmurHash2 block.
package mh2_pkg;

  localparam logic [31:0] MixMul = 32'h5bd1e995;
  localparam int unsigned MixShift = 24;
  localparam int unsigned FinShiftA = 13;
  localparam int unsigned FinShiftB = 15;

  localparam int unsigned FifoDepthDefault = 2;

  // Input word: message_length, data_word, byte_count, padded to bytes.
  localparam int unsigned InTdataW = 72;
  localparam int unsigned OutTdataW = 32;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_PART = 2'd1,
    KIND_FULL = 2'd2
  } kind_e;

  // One classified word on its way from the front to the back.
  typedef struct packed {
    logic        first;
    logic [31:0] seed;
    logic [31:0] word;
    kind_e       kind;
    logic        last;
  } item_t;

endpackage

// ===== sv/mh2_fifo.sv =====
// Small register queue between the front and the back.
module mh2_fifo #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/mh2_front.sv =====
// Front end: takes input words, tracks message starts and classifies each word.
module mh2_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [mh2_pkg::InTdataW-1:0] s_axis_tdata,
  input  logic                         s_axis_tlast,
  output logic                         item_valid_o,
  input  logic                         item_ready_i,
  output mh2_pkg::item_t               item_o
);

  import mh2_pkg::*;

  logic        in_msg_q;
  logic [31:0] msg_len;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic [31:0] byte_mask;
  logic        accept;

  assign msg_len    = s_axis_tdata[31:0];
  assign data_word  = s_axis_tdata[63:32];
  assign byte_count = s_axis_tdata[66:64];

  assign s_axis_tready = item_ready_i;
  assign item_valid_o  = s_axis_tvalid;
  assign accept        = s_axis_tvalid && item_ready_i;

  always_comb begin
    case (byte_count)
      3'd0:    byte_mask = 32'h0000_0000;
      3'd1:    byte_mask = 32'h0000_00ff;
      3'd2:    byte_mask = 32'h0000_ffff;
      3'd3:    byte_mask = 32'h00ff_ffff;
      default: byte_mask = 32'hffff_ffff;
    endcase
  end

  always_comb begin
    item_o.first = !in_msg_q;
    item_o.seed  = msg_len;
    item_o.word  = data_word & byte_mask;
    item_o.last  = s_axis_tlast;
    // Counts of four and up act as a full word.
    if (byte_count inside {[3'd4:3'd7]}) begin
      item_o.kind = KIND_FULL;
    end else if (byte_count == 3'd0) begin
      item_o.kind = KIND_NONE;
    end else begin
      item_o.kind = KIND_PART;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_msg_q <= 1'b0;
    end else if (accept) begin
      in_msg_q <= !s_axis_tlast;
    end
  end

endmodule

// ===== sv/mh2_back.sv =====
// Back end: hash recurrence, finalization and the result register.
module mh2_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          item_valid_i,
  output logic                          item_ready_o,
  input  mh2_pkg::item_t                item_i,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mh2_pkg::OutTdataW-1:0] m_axis_tdata
);

  import mh2_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MIX  = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] h_q, h_d;
  logic [31:0] hm_q, hm_d;
  logic [31:0] t_q, t_d;
  logic        last_q, last_d;
  logic        out_valid_q;
  logic [31:0] out_data_q;
  logic [31:0] base;
  logic [31:0] mul_a_op;
  logic [31:0] prod_a, prod_b;
  logic        out_free;
  logic        fin_fire;
  logic        pop;

  assign item_ready_o  = (state_q == S_IDLE);
  assign pop           = item_valid_i && item_ready_o;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign base          = item_i.first ? item_i.seed : h_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Shared multiplier A serves every step; B only scales the hash on a full word.
  always_comb begin
    case (state_q)
      S_MIX:   mul_a_op = t_q ^ (t_q >> MixShift);
      S_FIN:   mul_a_op = h_q ^ (h_q >> FinShiftA);
      default: mul_a_op = (item_i.kind == KIND_FULL) ? item_i.word : (base ^ item_i.word);
    endcase
  end

  assign prod_a = mul_a_op * MixMul;
  assign prod_b = base * MixMul;

  always_comb begin
    state_d  = state_q;
    h_d      = h_q;
    hm_d     = hm_q;
    t_d      = t_q;
    last_d   = last_q;
    fin_fire = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (pop) begin
          last_d = item_i.last;
          case (item_i.kind)
            KIND_FULL: begin
              t_d     = prod_a;
              hm_d    = prod_b;
              state_d = S_MIX;
            end
            KIND_PART: begin
              h_d     = prod_a;
              state_d = item_i.last ? S_FIN : S_IDLE;
            end
            default: begin
              h_d     = base;
              state_d = item_i.last ? S_FIN : S_IDLE;
            end
          endcase
        end
      end
      S_MIX: begin
        h_d     = hm_q ^ prod_a;
        state_d = last_q ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (out_free) begin
          fin_fire = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    h_q    <= h_d;
    hm_q   <= hm_d;
    t_q    <= t_d;
    last_q <= last_d;
    if (fin_fire) begin
      out_data_q <= prod_a ^ (prod_a >> FinShiftB);
    end
  end

`ifndef SYNTHESIS
  // The second mix step only follows a full word taken from the queue.
  a_mix_after_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MIX |-> $past(pop && item_i.kind == KIND_FULL))
    else $error("mix step without a full word");

  // A result appears only out of the finalize step.
  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result without finalize");

  // Finalize waits while the result register is still occupied.
  a_fin_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN && out_valid_q && !m_axis_tready |=> state_q == S_FIN)
    else $error("finalize overran a stalled result");
`endif

endmodule

// ===== sv/murmur2_hash32.sv =====
// Top level of the streaming 32-bit MurmurHash2 engine.
//
// Computes the 32-bit MurmurHash2 of a byte message seeded with its own length.
// Feed one little-endian word per beat on the slave stream: tdata carries the
// message length in bits 31:0 (read only on the first word of a message), the
// four data bytes in bits 63:32 (first byte lowest) and the valid byte count
// in bits 66:64; tlast marks the final word. Counts below four are expected
// only on the last word; counts above four act as four, and bytes beyond the
// count are ignored. An empty message is a single last word with count zero.
// One hashed result leaves on the master stream per message. The front end
// takes a word every cycle while the queue of FifoDepth entries has room; the
// back end then hashes a full word in two multiplier passes of the word mix
// (idle step, then mix step), a partial or empty word in the idle step alone,
// and finalizes the last word in a further finalize step. It takes no new
// word while a mix or finalize step is pending, so its pace is set by the
// dependent multiply chain of the hash recurrence. The result register lets
// the back end work on the next message while a finished hash waits to be taken.
module murmur2_hash32 #(
  parameter int unsigned FifoDepth = mh2_pkg::FifoDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [31:0] message_length, [63:32] data_word, [66:64] byte_count, [71:67] zero
  input  logic [mh2_pkg::InTdataW-1:0]  s_axis_tdata_i,
  input  logic                          s_axis_tlast_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [31:0] hash_value
  output logic [mh2_pkg::OutTdataW-1:0] m_axis_tdata_o
);

  import mh2_pkg::*;

  item_t front_item, back_item;
  logic  front_valid, front_ready;
  logic  back_valid, back_ready;

  // Accept and classify words; track the start of each message.
  mh2_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid_i),
    .s_axis_tready (s_axis_tready_o),
    .s_axis_tdata  (s_axis_tdata_i),
    .s_axis_tlast  (s_axis_tlast_i),
    .item_valid_o  (front_valid),
    .item_ready_i  (front_ready),
    .item_o        (front_item)
  );

  // Buffer classified words so the front keeps accepting while the back works.
  mh2_fifo #(
    .Width ($bits(item_t)),
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_item),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_item)
  );

  // Run the hash recurrence, finalize and hold the result.
  mh2_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (back_valid),
    .item_ready_o  (back_ready),
    .item_i        (back_item),
    .m_axis_tvalid (m_axis_tvalid_o),
    .m_axis_tready (m_axis_tready_i),
    .m_axis_tdata  (m_axis_tdata_o)
  );

endmodule
